>>> rtl/lmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane marker deviation package
// Shared widths, reset values, configuration layout and the command word that
// passes from the pixel front end to the deviation back end.
// ----------------------------------------------------------------------------
package lmd_pkg;

  // Defaults of the top-level parameters.
  localparam int RowStepDef      = 10;
  localparam int BottomOffsetDef = 8;
  localparam int FracBitsDef     = 12;
  localparam int CoordBitsDef    = 11;

  // Register widths.
  localparam int ThreshW   = 8;
  localparam int WidthW    = 12;
  localparam int HeightW   = 12;
  localparam int CtrlRowW  = 11;
  localparam int DistW     = 10;
  localparam int DeadBandW = 15;
  localparam int CfgDataW  = 15;
  localparam int CfgIdxW   = 3;

  // Result and internal widths.
  localparam int IntenW    = 8;
  localparam int ResW      = 16;
  localparam int MagW      = 14;
  localparam int FifoDepth = 4;

  // Register reset values.
  localparam logic [ThreshW-1:0]   ThreshRst   = ThreshW'(200);
  localparam logic [WidthW-1:0]    WidthRst    = WidthW'(640);
  localparam logic [HeightW-1:0]   HeightRst   = HeightW'(480);
  localparam logic [CtrlRowW-1:0]  CtrlRowRst  = CtrlRowW'(462);
  localparam logic [DistW-1:0]     DistRst     = DistW'(280);
  localparam logic [DeadBandW-1:0] DeadBandRst = DeadBandW'(41);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_WIDTH     = 3'd1,
    CFG_HEIGHT    = 3'd2,
    CFG_CTRL_ROW  = 3'd3,
    CFG_DISTANCE  = 3'd4,
    CFG_DEAD_BAND = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ThreshW-1:0]   threshold;
    logic [WidthW-1:0]    img_width;
    logic [HeightW-1:0]   img_height;
    logic [CtrlRowW-1:0]  ctrl_row;
    logic [DistW-1:0]     distance;
    logic [DeadBandW-1:0] dead_band;
  } cfg_t;

  // One command per item that has any effect on the back end.
  typedef struct packed {
    logic            clear;    // frame start: forget the control result
    logic            set;      // control row closed
    logic            missing;  // control row had no marker
    logic            report;   // frame end: give a result
    logic            neg;      // sign of the half-pixel numerator
    logic [MagW-1:0] mag;      // magnitude of the half-pixel numerator
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } bk_state_e;

  // A marker distance of zero behaves as one.
  function automatic logic [DistW-1:0] eff_distance(input logic [DistW-1:0] d);
    eff_distance = (d == '0) ? DistW'(1) : d;
  endfunction

endpackage

>>> rtl/lmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane marker deviation channels
// Pixel channel and result channel, each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface lmd_pix_if #(
  parameter int CoordBits = lmd_pkg::CoordBitsDef
);
  logic                       valid;
  logic                       ready;
  logic [lmd_pkg::IntenW-1:0] intensity;
  logic [CoordBits-1:0]       column;
  logic [CoordBits-1:0]       row;
  logic                       frame_start;
  logic                       frame_end;

  modport source (output valid, intensity, column, row, frame_start, frame_end,
                  input ready);
  modport sink   (input valid, intensity, column, row, frame_start, frame_end,
                  output ready);
endinterface

interface lmd_res_if;
  logic                            valid;
  logic                            ready;
  logic signed [lmd_pkg::ResW-1:0] deviation;
  logic signed [lmd_pkg::ResW-1:0] steering;
  logic                            slow;
  logic                            lines_missing;

  modport source (output valid, deviation, steering, slow, lines_missing, input ready);
  modport sink   (input valid, deviation, steering, slow, lines_missing, output ready);
endinterface

>>> rtl/lmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane marker deviation command queue
// Short first-in first-out queue of commands between front end and back end.
// ----------------------------------------------------------------------------
module lmd_fifo #(
  parameter int Depth = lmd_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lmd_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output lmd_pkg::cmd_t data_o,
  output logic          empty_o
);
  import lmd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/lmd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane marker deviation front end
// Takes one pixel per clock unless stalled, decides whether its row is scanned,
// tracks the markers nearest the centre and issues commands for the back end.
// ----------------------------------------------------------------------------
module lmd_front #(
  parameter int RowStep      = lmd_pkg::RowStepDef,
  parameter int BottomOffset = lmd_pkg::BottomOffsetDef,
  parameter int CoordBits    = lmd_pkg::CoordBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lmd_pkg::cfg_t cfg_i,
  lmd_pix_if.sink       pix_i,
  input  logic          fifo_full_i,
  output logic          push_o,
  output lmd_pkg::cmd_t cmd_o
);
  import lmd_pkg::*;

  localparam int DiffW   = HeightW;
  localparam int ExtW    = HeightW + 1;
  localparam int RecipW  = DiffW + 1;
  localparam int ProdW   = DiffW + RecipW;
  localparam int Recip   = (1 << DiffW) / RowStep;
  localparam int MulW    = DiffW + 8;
  localparam int ColW    = WidthW + 1;
  localparam int SnW     = MagW + 1;
  localparam int FiveW   = HeightW + 4;

  // Stage 1: pixel plus row range checks and the reciprocal product.
  logic                 s1_valid_q;
  logic [IntenW-1:0]    s1_int_q;
  logic [CoordBits-1:0] s1_col_q, s1_row_q;
  logic                 s1_fs_q, s1_fe_q, s1_range_q;
  logic [DiffW-1:0]     s1_diff_q;
  logic [ProdW-1:0]     s1_prod_q;

  // Stage 2: pixel plus the scanned-row decision.
  logic                 s2_valid_q;
  logic [IntenW-1:0]    s2_int_q;
  logic [CoordBits-1:0] s2_col_q, s2_row_q;
  logic                 s2_fs_q, s2_fe_q, s2_scan_q;

  // Marker state.
  logic [CoordBits-1:0] lhit_q, rhit_q, lfb_q, rfb_q;
  logic                 lok_q, rok_q, lfbok_q, rfbok_q;
  logic [CoordBits-1:0] lhit_d, rhit_d, lfb_d, rfb_d;
  logic                 lok_d, rok_d, lfbok_d, rfbok_d;

  logic                 adv;
  logic [ExtW-1:0]      first_row, row_x;
  logic                 above, five_gt;
  logic [DiffW-1:0]     diff;
  logic [ProdW-1:0]     prod;
  logic [MulW-1:0]      q_step, rem, rem_c;
  logic                 scan_d;

  logic [ColW-1:0]      col_x, w_x, half_x;
  logic [DistW-1:0]     mk_dist;
  logic [SnW-1:0]       num;
  logic                 set_c, miss_c;

  // The pipeline only stops when the last stage has a command and no room.
  assign adv         = !(s2_valid_q && push_o && fifo_full_i);
  assign pix_i.ready = adv;

  // ---- stage 1 logic ----
  assign first_row = ExtW'(cfg_i.img_height) - ExtW'(BottomOffset);
  assign row_x     = ExtW'(pix_i.row);
  assign above     = $signed(row_x) > $signed(first_row);
  assign diff      = DiffW'(first_row - row_x);
  assign five_gt   = ((FiveW'(pix_i.row) << 2) + FiveW'(pix_i.row)) >
                     ((FiveW'(cfg_i.img_height) << 1) + FiveW'(cfg_i.img_height));
  assign prod      = ProdW'(diff) * ProdW'(Recip);

  // ---- stage 2 logic: remainder by the row step, one correction ----
  assign q_step = MulW'(s1_prod_q >> DiffW) * MulW'(RowStep);
  assign rem    = MulW'(s1_diff_q) - q_step;
  assign rem_c  = (rem >= MulW'(RowStep)) ? rem - MulW'(RowStep) : rem;
  assign scan_d = s1_range_q && (rem_c == '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_int_q   <= pix_i.intensity;
      s1_col_q   <= pix_i.column;
      s1_row_q   <= pix_i.row;
      s1_fs_q    <= pix_i.frame_start;
      s1_fe_q    <= pix_i.frame_end;
      s1_range_q <= !above && five_gt;
      s1_diff_q  <= diff;
      s1_prod_q  <= prod;
      s2_int_q   <= s1_int_q;
      s2_col_q   <= s1_col_q;
      s2_row_q   <= s1_row_q;
      s2_fs_q    <= s1_fs_q;
      s2_fe_q    <= s1_fe_q;
      s2_scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pix_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  // ---- stage 3: marker tracking and row close ----
  assign col_x   = ColW'(s2_col_q);
  assign w_x     = ColW'(cfg_i.img_width);
  assign half_x  = ColW'(cfg_i.img_width >> 1);
  assign mk_dist = eff_distance(cfg_i.distance);

  always_comb begin
    lhit_d  = lhit_q;
    rhit_d  = rhit_q;
    lok_d   = lok_q;
    rok_d   = rok_q;
    lfb_d   = lfb_q;
    rfb_d   = rfb_q;
    lfbok_d = lfbok_q;
    rfbok_d = rfbok_q;
    set_c   = 1'b0;
    miss_c  = 1'b0;
    num     = '0;

    if (s2_fs_q) begin
      lfb_d   = '0;
      rfb_d   = '0;
      lfbok_d = 1'b0;
      rfbok_d = 1'b0;
      lhit_d  = '0;
      rhit_d  = '0;
      lok_d   = 1'b0;
      rok_d   = 1'b0;
    end
    if (s2_col_q == '0) begin
      lhit_d = '0;
      rhit_d = '0;
      lok_d  = 1'b0;
      rok_d  = 1'b0;
    end

    if ((col_x < w_x) && s2_scan_q) begin
      if (s2_int_q >= cfg_i.threshold) begin
        if ((col_x >= ColW'(1)) && (col_x <= half_x) &&
            (!lok_d || (s2_col_q > lhit_d))) begin
          lhit_d = s2_col_q;
          lok_d  = 1'b1;
        end
        if ((col_x >= half_x) && (!rok_d || (s2_col_q < rhit_d))) begin
          rhit_d = s2_col_q;
          rok_d  = 1'b1;
        end
      end
      // The last column closes the row and refreshes the fallbacks.
      if (col_x == w_x - ColW'(1)) begin
        if (lok_d) begin
          lfb_d   = lhit_d;
          lfbok_d = 1'b1;
        end
        if (rok_d) begin
          rfb_d   = rhit_d;
          rfbok_d = 1'b1;
        end
        if (ColW'(s2_row_q) == ColW'(cfg_i.ctrl_row)) begin
          set_c = 1'b1;
          priority if (rfbok_d && (rfb_d != '0)) begin
            num = (SnW'(rfb_d) << 1) - SnW'(cfg_i.img_width) - (SnW'(mk_dist) << 1);
          end else if (lfbok_d && (lfb_d != '0)) begin
            num = (SnW'(mk_dist) << 1) - SnW'(cfg_i.img_width) + (SnW'(lfb_d) << 1);
          end else begin
            miss_c = 1'b1;
          end
        end
        lhit_d = '0;
        rhit_d = '0;
        lok_d  = 1'b0;
        rok_d  = 1'b0;
      end
    end
  end

  assign cmd_o.clear   = s2_fs_q;
  assign cmd_o.set     = set_c;
  assign cmd_o.missing = miss_c;
  assign cmd_o.report  = s2_fe_q;
  assign cmd_o.neg     = num[SnW-1];
  assign cmd_o.mag     = MagW'(num[SnW-1] ? -num : num);
  assign push_o        = s2_valid_q && (s2_fs_q || set_c || s2_fe_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lhit_q  <= '0;
      rhit_q  <= '0;
      lfb_q   <= '0;
      rfb_q   <= '0;
      lok_q   <= 1'b0;
      rok_q   <= 1'b0;
      lfbok_q <= 1'b0;
      rfbok_q <= 1'b0;
    end else if (s2_valid_q && adv) begin
      lhit_q  <= lhit_d;
      rhit_q  <= rhit_d;
      lfb_q   <= lfb_d;
      rfb_q   <= rfb_d;
      lok_q   <= lok_d;
      rok_q   <= rok_d;
      lfbok_q <= lfbok_d;
      rfbok_q <= rfbok_d;
    end
  end

endmodule

>>> rtl/lmd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane marker deviation back end
// Executes queued commands: scales the control-row numerator with a
// bit-serial divider, keeps the frame's control result and forms the
// frame-end result with steering and speed decision.
// ----------------------------------------------------------------------------
module lmd_back #(
  parameter int FracBits = lmd_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lmd_pkg::cfg_t cfg_i,
  input  logic          fifo_empty_i,
  input  lmd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  lmd_res_if.source     res_o
);
  import lmd_pkg::*;

  localparam int DivW   = MagW + FracBits + 1;
  localparam int CntW   = $clog2(DivW);
  localparam int RemW   = DistW + 1;
  localparam int TrialW = RemW + 1;
  localparam int AbsW   = ResW + 1;
  localparam logic [DivW-1:0] SatPos = DivW'((1 << (ResW - 1)) - 1);
  localparam logic [DivW-1:0] SatNeg = DivW'(1 << (ResW - 1));

  bk_state_e         state_q, state_d;
  logic [DivW-1:0]   num_q, num_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q, neg_d, rep_q, rep_d;
  logic [ResW-1:0]   dev_q, dev_d, held_q, held_d;
  logic              miss_q, miss_d;

  logic              out_valid_q, out_valid_d, out_load;
  logic [ResW-1:0]   out_dev_q, out_steer_q;
  logic              out_slow_q, out_nl_q;

  logic [DistW-1:0]  mk_dist;
  logic [TrialW-1:0] divisor, trial;
  logic              ge;
  logic [RemW-1:0]   rem_step;
  logic [DivW-1:0]   quo_step;
  logic [ResW-1:0]   sat_dev;

  logic [AbsW-1:0]   dev_ext, dev_abs;
  logic              exceed;
  logic [ResW-1:0]   r_dev, r_steer;
  logic              r_slow;

  // One quotient bit per cycle, restoring form.
  assign mk_dist  = eff_distance(cfg_i.distance);
  assign divisor  = TrialW'({mk_dist, 1'b0});
  assign trial    = {rem_q, num_q[DivW-1]};
  assign ge       = (trial >= divisor);
  assign rem_step = RemW'(ge ? trial - divisor : trial);
  assign quo_step = {num_q[DivW-2:0], ge};

  always_comb begin
    if (neg_q) begin
      sat_dev = (quo_step > SatNeg) ? ResW'(SatNeg) : ResW'(-quo_step);
    end else begin
      sat_dev = (quo_step > SatPos) ? ResW'(SatPos) : ResW'(quo_step);
    end
  end

  // Frame-end result from the stored control deviation.
  assign dev_ext = {dev_q[ResW-1], dev_q};
  assign dev_abs = dev_q[ResW-1] ? -dev_ext : dev_ext;
  assign exceed  = dev_abs > AbsW'(cfg_i.dead_band);

  always_comb begin
    if (miss_q) begin
      r_dev   = '0;
      r_steer = held_q;
      r_slow  = 1'b1;
    end else begin
      r_dev   = dev_q;
      r_steer = exceed ? dev_q : '0;
      r_slow  = exceed;
    end
  end

  always_comb begin
    state_d  = state_q;
    num_d    = num_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    rep_d    = rep_q;
    dev_d    = dev_q;
    miss_d   = miss_q;
    held_d   = held_q;
    pop_o    = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o = 1'b1;
          rep_d = cmd_i.report;
          if (cmd_i.clear) begin
            dev_d  = '0;
            miss_d = 1'b0;
          end
          if (cmd_i.set && !cmd_i.missing) begin
            num_d   = (DivW'(cmd_i.mag) << FracBits) + DivW'(mk_dist);
            rem_d   = '0;
            cnt_d   = '0;
            neg_d   = cmd_i.neg;
            state_d = BK_DIV;
          end else begin
            if (cmd_i.set) begin
              dev_d  = '0;
              miss_d = 1'b1;
            end
            if (cmd_i.report) begin
              state_d = BK_OUT;
            end
          end
        end
      end
      BK_DIV: begin
        num_d = quo_step;
        rem_d = rem_step;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivW - 1)) begin
          dev_d   = sat_dev;
          miss_d  = 1'b0;
          state_d = rep_q ? BK_OUT : BK_IDLE;
        end
      end
      BK_OUT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          if (!miss_q) begin
            held_d = r_steer;
          end
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      rep_q       <= 1'b0;
      dev_q       <= '0;
      miss_q      <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rep_q       <= rep_d;
      dev_q       <= dev_d;
      miss_q      <= miss_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    if (out_load) begin
      out_dev_q   <= r_dev;
      out_steer_q <= r_steer;
      out_slow_q  <= r_slow;
      out_nl_q    <= miss_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.deviation     = out_dev_q;
  assign res_o.steering      = out_steer_q;
  assign res_o.slow          = out_slow_q;
  assign res_o.lines_missing = out_nl_q;

endmodule

>>> rtl/lane_marker_deviation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane marker deviation
// Finds lane markers on scanned rows of an intensity stream and reports the
// lateral deviation, a steering value and a slow flag at each frame end.
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock by a three-stage front end that checks the
// row, tracks the markers nearest the centre and closes rows. Each item that
// starts or ends a frame or closes the control row leaves a command in a
// four-entry queue. The back end takes one command per cycle while idle; a
// command that closes the control row with a marker adds a bit-serial
// division that turns it into a Q3.FracBits deviation. A frame-end command,
// or the last division step when the same item also closed the control row,
// moves the back end to its output state, which loads the result register
// once that register is free or being emptied. The front end stalls only
// when the queue is full, which happens when commands arrive faster than the
// back end retires them: more than four during one division, or while a
// result waits for the receiver.
// ----------------------------------------------------------------------------
module lane_marker_deviation #(
  parameter int RowStep      = lmd_pkg::RowStepDef,
  parameter int BottomOffset = lmd_pkg::BottomOffsetDef,
  parameter int FracBits     = lmd_pkg::FracBitsDef,
  parameter int CoordBits    = lmd_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lmd_pix_if.sink                      pix_i,
  lmd_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [lmd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lmd_pkg::CfgDataW-1:0] cfg_data_i
);
  import lmd_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, head_cmd;
  logic fifo_push, fifo_pop, fifo_full, fifo_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= ThreshRst;
      cfg_q.img_width  <= WidthRst;
      cfg_q.img_height <= HeightRst;
      cfg_q.ctrl_row   <= CtrlRowRst;
      cfg_q.distance   <= DistRst;
      cfg_q.dead_band  <= DeadBandRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD: cfg_q.threshold  <= cfg_data_i[ThreshW-1:0];
        CFG_WIDTH:     cfg_q.img_width  <= cfg_data_i[WidthW-1:0];
        CFG_HEIGHT:    cfg_q.img_height <= cfg_data_i[HeightW-1:0];
        CFG_CTRL_ROW:  cfg_q.ctrl_row   <= cfg_data_i[CtrlRowW-1:0];
        CFG_DISTANCE:  cfg_q.distance   <= cfg_data_i[DistW-1:0];
        CFG_DEAD_BAND: cfg_q.dead_band  <= cfg_data_i[DeadBandW-1:0];
        default: begin
        end
      endcase
    end
  end

  lmd_front #(
    .RowStep      (RowStep),
    .BottomOffset (BottomOffset),
    .CoordBits    (CoordBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_i       (pix_i),
    .fifo_full_i (fifo_full),
    .push_o      (fifo_push),
    .cmd_o       (push_cmd)
  );

  lmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (head_cmd),
    .empty_o (fifo_empty)
  );

  lmd_back #(
    .FracBits (FracBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (fifo_empty),
    .cmd_i        (head_cmd),
    .pop_o        (fifo_pop),
    .res_o        (res_o)
  );

  // While a command waits on a full queue, no pixel is taken.
  a_stall_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_push && fifo_full) |-> !pix_i.ready)
    else $error("pixel taken while the command queue is full");

  // The back end must never take a command from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("command popped from empty queue");

  // A frame without lines reports zero deviation with the slow flag set.
  a_lines_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.lines_missing) |-> ((res_o.deviation == '0) && res_o.slow))
    else $error("missing-lines result with deviation or full speed");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane marker deviation testbench
// Streams pixel frames into the block under randomly changing register
// settings, predicts every frame-end result in a local tracker of its own and
// compares each delivered result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lmd_pkg::*;

  localparam int IdlePct      = 23;
  localparam int HoldCycles   = 500;
  localparam int SettleCycles = 200;
  localparam int RandItems    = 2000;
  localparam int MinPasses    = 10;
  localparam int FrameItems   = 120;
  localparam int CycleLimit   = 500000;

  typedef struct packed {
    logic [IntenW-1:0]       inten;
    logic [CoordBitsDef-1:0] col;
    logic [CoordBitsDef-1:0] row;
    logic                    fs;
    logic                    fe;
  } pixel_t;

  typedef struct packed {
    logic signed [ResW-1:0] dev;
    logic signed [ResW-1:0] steer;
    logic                   slow;
    logic                   lines_missing;
  } lane_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic   pix_valid = 1'b0;
  pixel_t pix_item  = '0;
  logic   rx_ready  = 1'b0;

  lmd_pix_if pix_if ();
  lmd_res_if res_if ();

  assign pix_if.valid       = pix_valid;
  assign pix_if.intensity   = pix_item.inten;
  assign pix_if.column      = pix_item.col;
  assign pix_if.row         = pix_item.row;
  assign pix_if.frame_start = pix_item.fs;
  assign pix_if.frame_end   = pix_item.fe;
  assign res_if.ready       = rx_ready;

  lane_marker_deviation u_top (
    .clk_i,
    .rst_ni,
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Register copies as the block holds them.
  int cfg_thr  = int'(ThreshRst);
  int cfg_w    = int'(WidthRst);
  int cfg_h    = int'(HeightRst);
  int cfg_crow = int'(CtrlRowRst);
  int cfg_dist = int'(DistRst);
  int cfg_db   = int'(DeadBandRst);

  // Marker tracker state.
  int l_hit, r_hit, l_fb, r_fb;
  bit l_ok, r_ok, lfb_ok, rfb_ok;
  int ctrl_dev;
  bit ctrl_miss;
  int held_steer;

  pixel_t    pending_pixels[$];
  lane_res_t expected_reports[$];
  lane_res_t next_report;
  lane_res_t want;

  int idle_pct      = IdlePct;
  int queued_items  = 0;
  int fail_count    = 0;
  int cycle_count   = 0;
  int rx_hold_left  = 0;
  bit rx_hold_req   = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- prediction ----------------

  function automatic void clear_frame_state();
    l_hit = 0; r_hit = 0; l_fb = 0; r_fb = 0;
    l_ok = 0; r_ok = 0; lfb_ok = 0; rfb_ok = 0;
    ctrl_dev = 0;
    ctrl_miss = 0;
  endfunction

  function automatic bit row_scanned(int rw);
    int first;
    first = cfg_h - BottomOffsetDef;
    if (rw > first) return 0;
    if (((first - rw) % RowStepDef) != 0) return 0;
    return (5 * rw) > (3 * cfg_h);
  endfunction

  // Half-pixel numerator to Q3.12, rounded half away from zero, saturated.
  function automatic int q12_scale(longint num);
    longint d, mag, q;
    d = (cfg_dist == 0) ? 1 : cfg_dist;
    mag = (num < 0) ? -num : num;
    q = (mag * (longint'(1) << FracBitsDef) + d) / (2 * d);
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic void close_scan_row(int rw);
    longint d;
    d = (cfg_dist == 0) ? 1 : cfg_dist;
    if (l_ok) begin
      l_fb = l_hit;
      lfb_ok = 1;
    end
    if (r_ok) begin
      r_fb = r_hit;
      rfb_ok = 1;
    end
    if (rw == cfg_crow) begin
      if (rfb_ok && r_fb > 0) begin
        ctrl_dev = q12_scale(2 * longint'(r_fb) - cfg_w - 2 * d);
        ctrl_miss = 0;
      end else if (lfb_ok && l_fb > 0) begin
        ctrl_dev = q12_scale(2 * d - cfg_w + 2 * longint'(l_fb));
        ctrl_miss = 0;
      end else begin
        ctrl_dev = 0;
        ctrl_miss = 1;
      end
    end
    l_ok = 0; r_ok = 0; l_hit = 0; r_hit = 0;
  endfunction

  function automatic bit track_pixel(input pixel_t px, output lane_res_t rep);
    int col, rw, half, dev, steer, mag;
    bit slow;
    rep = '0;
    col = int'(px.col);
    rw = int'(px.row);
    half = cfg_w / 2;
    if (px.fs) clear_frame_state();
    if (col == 0) begin
      l_ok = 0; r_ok = 0; l_hit = 0; r_hit = 0;
    end
    if (col < cfg_w && row_scanned(rw)) begin
      if (int'(px.inten) >= cfg_thr) begin
        if (col >= 1 && col <= half && (!l_ok || col > l_hit)) begin
          l_hit = col;
          l_ok = 1;
        end
        if (col >= half && (!r_ok || col < r_hit)) begin
          r_hit = col;
          r_ok = 1;
        end
      end
      if (col == cfg_w - 1) close_scan_row(rw);
    end
    if (!px.fe) return 0;
    if (ctrl_miss) begin
      dev = 0;
      steer = held_steer;
      slow = 1;
    end else begin
      dev = ctrl_dev;
      mag = (dev < 0) ? -dev : dev;
      if (mag > cfg_db) begin
        steer = dev;
        slow = 1;
      end else begin
        steer = 0;
        slow = 0;
      end
      held_steer = steer;
    end
    rep.dev = ResW'(dev);
    rep.steer = ResW'(steer);
    rep.slow = slow;
    rep.lines_missing = ctrl_miss;
    return 1;
  endfunction

  // ---------------- pixel driver ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && pix_if.ready) begin
        if (track_pixel(pix_item, next_report)) expected_reports.push_back(next_report);
      end
      if (!pix_valid || pix_if.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
          pix_item <= pending_pixels.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else begin
      if (rx_ready && res_if.valid) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result: deviation %0d steering %0d",
                 res_if.deviation, res_if.steering);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (res_if.deviation !== want.dev) begin
            $error("deviation: expected %0d, got %0d", want.dev, res_if.deviation);
            fail_count++;
          end
          if (res_if.steering !== want.steer) begin
            $error("steering: expected %0d, got %0d", want.steer, res_if.steering);
            fail_count++;
          end
          if (res_if.slow !== want.slow) begin
            $error("slow: expected %0d, got %0d", want.slow, res_if.slow);
            fail_count++;
          end
          if (res_if.lines_missing !== want.lines_missing) begin
            $error("lines_missing: expected %0d, got %0d", want.lines_missing,
                   res_if.lines_missing);
            fail_count++;
          end
        end
      end
      // A requested hold-off keeps the output stalled so the block backs up.
      if (rx_hold_req) begin
        rx_hold_left = HoldCycles;
        rx_hold_req = 1'b0;
      end
      if (rx_hold_left > 0) rx_hold_left--;
      rx_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic write_reg(input cfg_idx_e idx, input int value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CfgDataW'(value);
    case (idx)
      CFG_THRESHOLD: cfg_thr  = value & ((1 << ThreshW) - 1);
      CFG_WIDTH:     cfg_w    = value & ((1 << WidthW) - 1);
      CFG_HEIGHT:    cfg_h    = value & ((1 << HeightW) - 1);
      CFG_CTRL_ROW:  cfg_crow = value & ((1 << CtrlRowW) - 1);
      CFG_DISTANCE:  cfg_dist = value & ((1 << DistW) - 1);
      CFG_DEAD_BAND: cfg_db   = value & ((1 << DeadBandW) - 1);
      default: ;
    endcase
  endtask

  task automatic apply_config(input int thr, input int w, input int h, input int crow,
                              input int mdist, input int db);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_CTRL_ROW, crow);
    write_reg(CFG_DISTANCE, mdist);
    write_reg(CFG_DEAD_BAND, db);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(input int inten, input int col, input int rw,
                            input bit fs, input bit fe);
    pixel_t px;
    px.inten = IntenW'(inten);
    px.col = CoordBitsDef'(col);
    px.row = CoordBitsDef'(rw);
    px.fs = fs;
    px.fe = fe;
    pending_pixels.push_back(px);
    queued_items++;
  endtask

  task automatic push_noise();
    push_pixel($urandom_range(255), $urandom_range(2047), $urandom_range(2047),
               $urandom_range(99) < 5, $urandom_range(99) < 5);
  endtask

  function automatic int pick_intensity(int bright_pct);
    if ($urandom_range(99) < bright_pct) return $urandom_range(255, cfg_thr);
    if (cfg_thr == 0) return $urandom_range(255);
    return $urandom_range(cfg_thr - 1, 0);
  endfunction

  // Block goes idle: all items taken, all results in, divider given time.
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || pix_valid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One raster frame restricted to its scanned rows, with random defects.
  // Rows that would push the frame past its item budget are left out.
  task automatic push_frame(input int bright_pct);
    int scan_rows[$];
    int r, c, n, k, sent;
    bit fs_open;
    sent = 0;
    for (r = cfg_h - BottomOffsetDef; r >= 0 && 5 * r > 3 * cfg_h; r -= RowStepDef)
      scan_rows.push_front(r);
    fs_open = $urandom_range(1);
    if (!fs_open) push_pixel(pick_intensity(bright_pct), $urandom_range(cfg_w - 1), 0, 1, 0);
    foreach (scan_rows[i]) begin
      if ($urandom_range(99) < 12) continue;
      n = cfg_w;
      if ($urandom_range(99) < 8) n = $urandom_range(cfg_w - 1, 1);
      if (sent + n > FrameItems) continue;
      sent += n;
      for (c = 0; c < n; c++) begin
        push_pixel(pick_intensity(bright_pct), c, scan_rows[i], fs_open, 0);
        fs_open = 0;
        if ($urandom_range(99) < 2 && cfg_w <= 2047)
          push_pixel(255, $urandom_range(2047, cfg_w), scan_rows[i], 0, 0);
      end
      if ($urandom_range(99) < 5) begin
        for (c = 0; c < 4; c++) push_pixel(255, c, scan_rows[i] + 1, 0, 0);
      end
    end
    k = $urandom_range(99);
    if (k < 6 && !fs_open) begin
      // Frame left without an end; the next start discards it.
    end else if (k < 20) begin
      // End on the last column of the control row: close and report together.
      push_pixel(pick_intensity(bright_pct), cfg_w - 1, cfg_crow, fs_open, 1);
    end else begin
      push_pixel(pick_intensity(bright_pct), $urandom_range(cfg_w - 1), cfg_h - 1, fs_open, 1);
    end
  endtask

  task automatic random_config();
    int scan_rows[$];
    int w, h, crow, mdist, thr, db, k, r;
    k = $urandom_range(99);
    if (k < 60) w = $urandom_range(24, 2);
    else if (k < 90) w = $urandom_range(80, 25);
    else w = $urandom_range(110, 81);
    k = $urandom_range(99);
    if (k < 8) begin
      h = $urandom_range(23, 16);
    end else if (k < 75) begin
      h = $urandom_range(160, 24);
    end else if (k < 92) begin
      h = $urandom_range(600, 161);
    end else begin
      h = $urandom_range(2048, 601);
      if (w > 12) w = $urandom_range(12, 2);
    end
    for (r = h - BottomOffsetDef; r >= 0 && 5 * r > 3 * h; r -= RowStepDef)
      scan_rows.push_back(r);
    k = $urandom_range(99);
    if (scan_rows.size() != 0 && k < 80) crow = scan_rows[$urandom_range(scan_rows.size() - 1)];
    else if (scan_rows.size() != 0 && k < 90) crow = scan_rows[0] + 1;
    else crow = $urandom_range(2047);
    k = $urandom_range(99);
    if (k < 20) mdist = $urandom_range(4, 1);
    else if (k < 70) mdist = $urandom_range((w / 2 > 1) ? w / 2 : 1, 1);
    else mdist = $urandom_range(1023, 1);
    k = $urandom_range(99);
    if (k < 10) thr = 0;
    else if (k < 20) thr = 255;
    else thr = $urandom_range(250, 60);
    k = $urandom_range(99);
    if (k < 10) db = 0;
    else if (k < 20) db = 32767;
    else if (k < 70) db = $urandom_range(300);
    else db = $urandom_range(32767);
    apply_config(thr, w, h, crow, mdist, db);
  endtask

  // ---------------- test sequence ----------------

  initial begin
    int p, nframes, bright, c, k;
    clear_frame_state();
    held_steer = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Small raster: both sides found, threshold met exactly, a pixel outside
    // the width, then a frame with no marker so steering is held, then a frame
    // that starts and ends on one pixel and never closes the control row.
    apply_config(200, 8, 24, 16, 2, 0);
    push_pixel(0, 0, 0, 1, 0);
    push_pixel(255, 0, 16, 0, 0);
    push_pixel(10, 1, 16, 0, 0);
    push_pixel(199, 2, 16, 0, 0);
    push_pixel(255, 3, 16, 0, 0);
    push_pixel(200, 4, 16, 0, 0);
    push_pixel(255, 5, 16, 0, 0);
    push_pixel(0, 6, 16, 0, 0);
    push_pixel(255, 9, 16, 0, 0);
    push_pixel(0, 7, 16, 0, 0);
    push_pixel(50, 0, 23, 0, 1);
    push_pixel(0, 0, 0, 1, 0);
    for (c = 0; c < 8; c++) push_pixel(0, c, 16, 0, 0);
    push_pixel(0, 7, 23, 0, 1);
    push_pixel(255, 3, 16, 1, 1);
    wait_idle();

    // One-pixel rows: the only find is a right marker at column zero.
    apply_config(0, 1, 24, 16, 0, 41);
    push_pixel(0, 0, 16, 1, 0);
    push_pixel(0, 0, 23, 0, 1);
    wait_idle();

    // Zero marker distance acts as one.
    apply_config(128, 8, 24, 16, 0, 41);
    push_pixel(0, 0, 0, 1, 0);
    for (c = 0; c < 8; c++) push_pixel((c == 6) ? 255 : 0, c, 16, 0, 0);
    push_pixel(0, 0, 23, 0, 1);
    wait_idle();

    // Zero width: no row is ever examined or closed.
    apply_config(128, 0, 24, 16, 5, 41);
    push_pixel(255, 5, 16, 1, 0);
    push_pixel(255, 0, 16, 0, 1);
    wait_idle();

    // Largest coordinates: saturation on the negative and then the positive
    // side. Only the marker and the closing column of the control row are sent.
    apply_config(255, 2047, 2047, 2039, 1, 32767);
    for (k = 0; k < 2; k++) begin
      push_pixel(0, 0, 0, 1, 0);
      if (k == 0) push_pixel(255, 1, 2039, 0, 0);
      push_pixel((k == 0) ? 254 : 255, 2046, 2039, 0, 0);
      push_pixel(0, 5, 2047, 0, 1);
    end
    wait_idle();

    queued_items = 0;
    p = 0;
    while (queued_items < RandItems || p < MinPasses) begin
      idle_pct = (p >= 6 && p < 9) ? 0 : IdlePct;
      random_config();
      if (p == 3) begin
        // Stall the output while a burst of frame ends backs the block up.
        rx_hold_req = 1'b1;
        repeat (24) push_pixel($urandom_range(255), 0, 0, $urandom_range(1), 1);
      end
      nframes = (cfg_h > 600) ? 1 : $urandom_range(3, 1);
      bright = $urandom_range(20, 2);
      repeat (nframes) push_frame(bright);
      repeat ($urandom_range(3)) push_noise();
      wait_idle();
      p++;
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
